>>> src/tcw_pkg.sv
package tcw_pkg;

    localparam int COLS_DEFAULT = 80;
    localparam int ROWS_DEFAULT = 25;

    localparam int CMD_W    = 2;
    localparam int WORD_W   = 16;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int COLOR_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK = 2'd1;

    localparam logic [COLOR_W-1:0] FORE_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_RETURN    = 8'h0d;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [WORD_W-1:0]  char_word;
        logic [INDEX_W-1:0] read_index;
    } tcw_in_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic [WORD_W-1:0]   read_data;
    } tcw_out_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_TAB,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_CLEAR,
        S_READ,
        S_RDATA,
        S_DONE
    } tcw_state_t;

endpackage

>>> src/tcw_ram.sv
module tcw_ram
    #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
    )
    (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tcw_seq.sv
module tcw_seq
    import tcw_pkg::*;
    #(
    parameter int COLS = COLS_DEFAULT,
    parameter int ROWS = ROWS_DEFAULT,
    localparam int CELLS = COLS * ROWS,
    localparam int AW = $clog2(CELLS),
    localparam int CW = $clog2(COLS)
    )
    (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  tcw_in_t            item,
    input  logic [COLOR_W-1:0] fore,
    input  logic [COLOR_W-1:0] back,
    output logic               idle,
    output logic               done_valid,
    input  logic               done_ack,
    output logic [AW-1:0]      done_cursor,
    output logic [WORD_W-1:0]  done_data,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [WORD_W-1:0]  ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  logic [WORD_W-1:0]  ram_rdata
    );

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW  = AW'(CELLS - COLS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

    tcw_state_t state_reg, state_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [AW-1:0]      src_reg, src_next;
    logic [AW-1:0]      dst_reg, dst_next;
    logic               pend_reg, pend_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0]  data_reg, data_next;
    logic [1:0]         tab_cnt_reg, tab_cnt_next;
    logic               more_tab_reg, more_tab_next;
    logic [7:0]         fill_attr_reg, fill_attr_next;

    logic [7:0]        def_attr;
    logic [WORD_W-1:0] col_word;
    logic              adv;
    logic              adv_more;
    logic [WORD_W-1:0] adv_word;

    assign def_attr = {back, fore};
    // A character word without attribute takes the configured colors.
    assign col_word = (word_reg[15:8] == 8'h00) ? {def_attr, word_reg[7:0]} : word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            cur_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            dst_reg      <= '0;
            src_reg      <= '0;
            pend_reg     <= 1'b0;
            tab_cnt_reg  <= '0;
            more_tab_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            dst_reg      <= dst_next;
            src_reg      <= src_next;
            pend_reg     <= pend_next;
            tab_cnt_reg  <= tab_cnt_next;
            more_tab_reg <= more_tab_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        idx_reg       <= idx_next;
        data_reg      <= data_next;
        fill_attr_reg <= fill_attr_next;
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        tab_cnt_next   = tab_cnt_reg;
        more_tab_next  = more_tab_reg;
        fill_attr_next = fill_attr_reg;
        ram_we         = 1'b0;
        ram_waddr      = dst_reg;
        ram_wdata      = '0;
        ram_raddr      = src_reg;
        done_valid     = 1'b0;
        adv            = 1'b0;
        adv_more       = 1'b0;
        adv_word       = '0;

        case (state_reg)
            S_INIT: begin
                ram_we = 1'b1;
                if (dst_reg == LAST_CELL) begin
                    dst_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    dst_next = dst_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    word_next = item.char_word;
                    idx_next  = item.read_index;
                    data_next = '0;
                    case (item.command)
                        CMD_PUT: begin
                            state_next = S_PUT;
                        end
                        CMD_CLEAR: begin
                            dst_next   = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_READ: begin
                            state_next = S_READ;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PUT: begin
                case (col_word[7:0])
                    CH_BACKSPACE: begin
                        if (cur_reg != '0) begin
                            cur_next  = cur_reg - AW'(1);
                            ram_we    = 1'b1;
                            ram_waddr = cur_reg - AW'(1);
                            ram_wdata = {col_word[15:8], CH_SPACE};
                            if (col_reg == '0) begin
                                col_next = LAST_COL;
                                row_next = row_reg - ROW_STEP;
                            end else begin
                                col_next = col_reg - CW'(1);
                            end
                        end
                        state_next = S_DONE;
                    end
                    CH_TAB: begin
                        tab_cnt_next = 2'd3;
                        state_next   = S_TAB;
                    end
                    CH_NEWLINE: begin
                        col_next = '0;
                        if (row_reg == LAST_ROW) begin
                            cur_next       = LAST_ROW;
                            src_next       = ROW_STEP;
                            dst_next       = '0;
                            pend_next      = 1'b0;
                            fill_attr_next = col_word[15:8];
                            more_tab_next  = 1'b0;
                            state_next     = S_COPY;
                        end else begin
                            cur_next   = row_reg + ROW_STEP;
                            row_next   = row_reg + ROW_STEP;
                            state_next = S_DONE;
                        end
                    end
                    CH_RETURN: begin
                        cur_next   = row_reg;
                        col_next   = '0;
                        state_next = S_DONE;
                    end
                    default: begin
                        adv      = 1'b1;
                        adv_word = col_word;
                    end
                endcase
            end
            S_TAB: begin
                adv          = 1'b1;
                adv_word     = {def_attr, CH_SPACE};
                adv_more     = (tab_cnt_reg != 2'd0);
                tab_cnt_next = tab_cnt_reg - 2'd1;
            end
            S_COPY: begin
                // Pipelined move: read one row ahead, write back the word read last beat.
                ram_raddr = src_reg;
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    dst_next  = dst_reg + AW'(1);
                end
                pend_next = 1'b1;
                if (src_reg == LAST_CELL) begin
                    state_next = S_DRAIN;
                end else begin
                    src_next = src_reg + AW'(1);
                end
            end
            S_DRAIN: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                dst_next   = dst_reg + AW'(1);
                state_next = S_FILL;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = {fill_attr_reg, CH_SPACE};
                if (dst_reg == LAST_CELL) begin
                    state_next = more_tab_reg ? S_TAB : S_DONE;
                end else begin
                    dst_next = dst_reg + AW'(1);
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = {4'h0, fore, CH_SPACE};
                if (dst_reg == LAST_CELL) begin
                    cur_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_DONE;
                end else begin
                    dst_next = dst_reg + AW'(1);
                end
            end
            S_READ: begin
                ram_raddr  = AW'(idx_reg);
                state_next = S_RDATA;
            end
            S_RDATA: begin
                data_next  = (32'(idx_reg) < CELLS) ? ram_rdata : '0;
                state_next = S_DONE;
            end
            S_DONE: begin
                done_valid = 1'b1;
                if (done_ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Store a non-control word at the cursor and advance; the last cell scrolls.
        if (adv) begin
            ram_we    = 1'b1;
            ram_waddr = cur_reg;
            ram_wdata = adv_word;
            if (cur_reg == LAST_CELL) begin
                cur_next       = LAST_ROW;
                row_next       = LAST_ROW;
                col_next       = '0;
                src_next       = ROW_STEP;
                dst_next       = '0;
                pend_next      = 1'b0;
                fill_attr_next = adv_word[15:8];
                more_tab_next  = adv_more;
                state_next     = S_COPY;
            end else begin
                cur_next = cur_reg + AW'(1);
                if (col_reg == LAST_COL) begin
                    col_next = '0;
                    row_next = row_reg + ROW_STEP;
                end else begin
                    col_next = col_reg + CW'(1);
                end
                state_next = adv_more ? S_TAB : S_DONE;
            end
        end
    end

    assign idle        = (state_reg == S_IDLE);
    assign done_cursor = cur_reg;
    assign done_data   = data_reg;

endmodule

>>> src/text_console_char_writer_core.sv
// Text console character writer.
// Items enter on the s_ channel (command, character word, read index) and each
// one yields exactly one beat on the m_ channel with the cursor after the
// operation and, for a read, the cell word (zero otherwise). Both channels use
// valid/ready. Colors are set through the cfg_ channel, index 0 foreground and
// index 1 background; cfg_ready is always high.
// A scroll moves one memory word per cycle through the single write port,
// and clear sweeps every cell through the same port. One item is worked
// on at a time; s_ready is high only while the sequencer idles, which it
// does again once the result is registered.
// After aresetn the cell memory is swept to zero, one cell per cycle, over
// all COLS*ROWS cells (2000 at the default size) before s_ready rises; the
// cursor resets to zero and the colors to 7 and 0.
// A finished result waits in an output register, so a stalled m_ready still
// lets the next item be accepted; that item then holds until the register
// frees.
module text_console_char_writer_core
    import tcw_pkg::*;
    #(
    parameter int COLS = COLS_DEFAULT,
    parameter int ROWS = ROWS_DEFAULT
    )
    (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tcw_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tcw_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
    );

    localparam int CELLS = COLS * ROWS;
    localparam int AW = $clog2(CELLS);

    logic [COLOR_W-1:0] fore_reg, fore_next;
    logic [COLOR_W-1:0] back_reg, back_next;
    logic               m_valid_reg, m_valid_next;
    tcw_out_t           m_data_reg, m_data_next;

    logic              idle;
    logic              done_valid;
    logic              done_ack;
    logic [AW-1:0]     done_cursor;
    logic [WORD_W-1:0] done_data;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign done_ack  = done_valid && (!m_valid_reg || m_ready);

    always_comb begin
        fore_next = fore_reg;
        back_next = back_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FORE: fore_next = cfg_data;
                CFG_BACK: back_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done_ack) begin
            m_valid_next           = 1'b1;
            m_data_next.cursor_pos = CURSOR_W'(done_cursor);
            m_data_next.read_data  = done_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fore_reg    <= FORE_RESET;
            back_reg    <= BACK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            fore_reg    <= fore_next;
            back_reg    <= back_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    tcw_seq #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_valid && s_ready),
        .item        (s_data),
        .fore        (fore_reg),
        .back        (back_reg),
        .idle        (idle),
        .done_valid  (done_valid),
        .done_ack    (done_ack),
        .done_cursor (done_cursor),
        .done_data   (done_data),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> bench/text_console_char_writer_core_tb.sv
module text_console_char_writer_core_tb;
    import tcw_pkg::*;

    localparam int SCREEN_COLS  = COLS_DEFAULT;
    localparam int SCREEN_CELLS = COLS_DEFAULT * ROWS_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    class screen_scoreboard;
        logic [WORD_W-1:0]  cells [SCREEN_CELLS];
        int unsigned        cursor;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        tcw_out_t           cursor_reports [$];
        int unsigned        mismatches;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor = 0;
            fore = FORE_RESET;
            back = BACK_RESET;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
            if (idx == CFG_FORE) begin
                fore = value;
            end else if (idx == CFG_BACK) begin
                back = value;
            end
        endfunction

        function logic [WORD_W-1:0] apply_default_attr(logic [WORD_W-1:0] raw);
            if (raw[15:8] == 8'h00) begin
                return {back, fore, raw[7:0]};
            end
            return raw;
        endfunction

        // Rows move up one; the freed bottom row takes the attribute of the
        // character that ran the cursor off the screen.
        function void scroll_screen(logic [WORD_W-1:0] w);
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
                cells[i] = cells[i + SCREEN_COLS];
            end
            for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) begin
                cells[i] = {w[15:8], CH_SPACE};
            end
            cursor -= SCREEN_COLS;
        endfunction

        function void type_char(logic [WORD_W-1:0] raw);
            logic [WORD_W-1:0] w;
            w = apply_default_attr(raw);
            case (w[7:0])
                CH_BACKSPACE: begin
                    if (cursor > 0) begin
                        cursor--;
                        cells[cursor] = {w[15:8], CH_SPACE};
                    end
                end
                CH_TAB: begin
                    repeat (4) type_char({8'h00, CH_SPACE});
                end
                CH_NEWLINE: begin
                    cursor = (cursor + SCREEN_COLS) / SCREEN_COLS * SCREEN_COLS;
                end
                CH_RETURN: begin
                    cursor = cursor / SCREEN_COLS * SCREEN_COLS;
                end
                default: begin
                    if (cursor < SCREEN_CELLS) cells[cursor] = w;
                    cursor++;
                end
            endcase
            if (cursor == SCREEN_CELLS) scroll_screen(w);
        endfunction

        function void note_command(tcw_in_t item);
            tcw_out_t report;
            report.read_data = '0;
            case (item.command)
                CMD_PUT: begin
                    type_char(item.char_word);
                end
                CMD_CLEAR: begin
                    foreach (cells[i]) cells[i] = {4'h0, fore, CH_SPACE};
                    cursor = 0;
                end
                CMD_READ: begin
                    if (item.read_index < SCREEN_CELLS) report.read_data = cells[item.read_index];
                end
                default: begin
                end
            endcase
            report.cursor_pos = cursor[CURSOR_W-1:0];
            cursor_reports.push_back(report);
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %s: expected %0h, got %0h", what, want, got);
            end
        endfunction

        function void check_report(tcw_out_t got);
            tcw_out_t want;
            if (cursor_reports.size() == 0) begin
                flag("unexpected beat", 32'(0), 32'(got));
                return;
            end
            want = cursor_reports.pop_front();
            if (got.cursor_pos !== want.cursor_pos) begin
                flag("cursor_pos", 32'(want.cursor_pos), 32'(got.cursor_pos));
            end
            if (got.read_data !== want.read_data) begin
                flag("read_data", 32'(want.read_data), 32'(got.read_data));
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    tcw_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    tcw_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    screen_scoreboard board = new();
    int unsigned      items_sent;
    int unsigned      reports_seen;
    bit               hold_done;

    text_console_char_writer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic tcw_in_t make_item(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word,
                                          logic [INDEX_W-1:0] index);
        tcw_in_t item;
        item.command = cmd;
        item.char_word = word;
        item.read_index = index;
        return item;
    endfunction

    function automatic logic [INDEX_W-1:0] index_near_cursor();
        return INDEX_W'((board.cursor + SCREEN_CELLS - $urandom_range(1, 120)) % SCREEN_CELLS);
    endfunction

    function automatic logic [7:0] random_attr();
        return ($urandom_range(99) < 40) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] control_char();
        case ($urandom_range(3))
            0: return CH_BACKSPACE;
            1: return CH_TAB;
            2: return CH_NEWLINE;
            default: return CH_RETURN;
        endcase
    endfunction

    // The sender skips its random gaps over a long stretch of items.
    task automatic offer_command(tcw_in_t item);
        bit quiet;
        quiet = (items_sent >= 700 && items_sent < 900);
        if (!quiet && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_command(item);
        items_sent++;
    endtask

    task automatic put_word(logic [WORD_W-1:0] word);
        offer_command(make_item(CMD_PUT, word, INDEX_W'($urandom_range(0, 2047))));
    endtask

    task automatic read_cell(logic [INDEX_W-1:0] index);
        offer_command(make_item(CMD_READ, 16'($urandom), index));
    endtask

    task automatic clear_screen();
        offer_command(make_item(CMD_CLEAR, 16'($urandom), INDEX_W'($urandom_range(0, 2047))));
    endtask

    // Lowers the input and waits for every outstanding beat to come back.
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (board.cursor_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_colors(logic [COLOR_W-1:0] fore, logic [COLOR_W-1:0] back);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FORE;
        cfg_data <= fore;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(CFG_FORE, fore);
        cfg_index <= CFG_BACK;
        cfg_data <= back;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(CFG_BACK, back);
        cfg_valid <= 1'b0;
    endtask

    task automatic type_line();
        int unsigned      len;
        logic [7:0]       attr;
        int unsigned      pick;
        len = $urandom_range(1, 40);
        attr = random_attr();
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                put_word({attr, ($urandom_range(1) == 0) ? CH_BACKSPACE : CH_TAB});
            end else if (pick < 13) begin
                put_word({random_attr(), 8'($urandom_range(0, 255))});
            end else begin
                put_word({attr, 8'($urandom_range(32, 126))});
            end
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            put_word({attr, CH_NEWLINE});
        end else if (pick < 85) begin
            put_word({attr, CH_RETURN});
        end
    endtask

    task automatic single_random();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            put_word({random_attr(), 8'($urandom_range(0, 255))});
        end else if (pick < 55) begin
            put_word({random_attr(), control_char()});
        end else if (pick < 80) begin
            read_cell(($urandom_range(1) == 0) ? index_near_cursor()
                                              : INDEX_W'($urandom_range(0, 2047)));
        end else if (pick < 84) begin
            clear_screen();
        end else if (pick < 90) begin
            offer_command(make_item(CMD_NONE, 16'($urandom), INDEX_W'($urandom_range(0, 2047))));
        end else begin
            put_word(16'($urandom));
        end
    endtask

    task automatic run_random(int unsigned count);
        int unsigned start;
        int unsigned pick;
        logic [7:0]  attr;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                type_line();
            end else if (pick < 78) begin
                single_random();
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 6)) read_cell(index_near_cursor());
            end else if (pick < 97) begin
                // A run of newlines pushes the cursor down, scrolling once it passes the last row.
                attr = random_attr();
                repeat ($urandom_range(5, 30)) put_word({attr, CH_NEWLINE});
            end else begin
                clear_screen();
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FORE;
        cfg_data <= '0;
        items_sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset contents and colors, out-of-range reads, and each control code.
        read_cell(11'd0);
        read_cell(INDEX_W'(SCREEN_CELLS - 1));
        read_cell(11'd2047);
        read_cell(INDEX_W'(SCREEN_CELLS));
        put_word(16'h0041);
        put_word(16'hff5a);
        put_word(16'h8000);
        read_cell(11'd0);
        read_cell(11'd1);
        put_word({8'h1e, CH_BACKSPACE});
        put_word({8'h00, CH_RETURN});
        put_word({8'h3c, CH_BACKSPACE});
        put_word({8'hc3, CH_TAB});
        put_word({8'h00, CH_NEWLINE});
        offer_command(make_item(CMD_NONE, 16'hffff, 11'd2047));
        read_cell(11'd3);
        put_word(16'hffff);
        clear_screen();
        read_cell(INDEX_W'(SCREEN_CELLS - 1));
        read_cell(11'd0);
        drain_reports();

        set_colors(4'hf, 4'hf);
        repeat (ROWS_DEFAULT) put_word({8'ha5, CH_NEWLINE});
        read_cell(INDEX_W'(SCREEN_CELLS - SCREEN_COLS));
        read_cell(INDEX_W'(SCREEN_CELLS - 1));
        read_cell(11'd0);
        put_word(16'h0041);
        clear_screen();
        read_cell(11'd5);
        drain_reports();

        set_colors(4'h0, 4'h0);
        run_random(280);
        drain_reports();
        set_colors(4'hf, 4'h0);
        run_random(280);
        drain_reports();
        set_colors(4'h0, 4'hf);
        run_random(280);
        drain_reports();
        set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
        run_random(280);
        drain_reports();
        set_colors(FORE_RESET, BACK_RESET);
        run_random(280);
        drain_reports();

        repeat (20) @(posedge aclk);
        if (board.mismatches == 0 && board.cursor_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off while the sender keeps
    // offering, and a stretch where every beat is taken at once.
    initial begin
        m_ready <= 1'b0;
        reports_seen = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                board.check_report(m_data);
                reports_seen++;
            end
            if (!hold_done && reports_seen >= 150) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (reports_seen >= 1000 && reports_seen < 1200) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 22);
            end
        end
    end

endmodule
